// ===== hw/rtl/dlm_pkg.sv =====
// Shared types and codes for the dancing-links matrix core.
// Used by dlm_ctrl, dlm_dpath and dancing_links_matrix_core; no dependencies.
`timescale 1ns / 1ps

package dlm_pkg;

	localparam logic [2:0] OP_RESET  = 3'd0;
	localparam logic [2:0] OP_BEGIN  = 3'd1;
	localparam logic [2:0] OP_SET    = 3'd2;
	localparam logic [2:0] OP_HIDE   = 3'd3;
	localparam logic [2:0] OP_UNHIDE = 3'd4;
	localparam logic [2:0] OP_READ   = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_POOL_FULL = 3'd1;
	localparam logic [2:0] ST_BAD_COL   = 3'd2;
	localparam logic [2:0] ST_BAD_NODE  = 3'd3;
	localparam logic [2:0] ST_BAD_CFG   = 3'd4;

	localparam logic CFG_PRIMARY   = 1'b0;
	localparam logic CFG_SECONDARY = 1'b1;

	localparam int          CNT_W    = 11;
	localparam logic [10:0] ROWS_MAX = 11'h7FF;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [5:0]  column;
		logic [10:0] node_index;
		logic [31:0] row_tag;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [10:0] result_node;
		logic [10:0] link_up;
		logic [10:0] link_down;
		logic [10:0] link_left;
		logic [10:0] link_right;
		logic [6:0]  head_column;
		logic [31:0] tag_out;
		logic [10:0] column_count;
		logic [10:0] rows_total;
		logic [10:0] nodes_total;
	} result_t;

	typedef enum logic [4:0] {
		CMD_IDLE, CMD_SWEEP, CMD_DECODE, CMD_BEGIN,
		CMD_SET1, CMD_SET2, CMD_SET3,
		CMD_HID1, CMD_HID2, CMD_HID3,
		CMD_UNH1, CMD_UNH2, CMD_UNH3, CMD_UNH4,
		CMD_RD1, CMD_RD2, CMD_RD3,
		CMD_DONE
	} cmd_t;

	typedef struct packed {
		cmd_t step;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic       pre_err;
		logic       walk_last;
		logic       sweep_last;
		logic       out_free;
	} dp_status_t;

endpackage

// ===== hw/rtl/dlm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dlm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/dlm_dpath.sv =====
// Datapath: link, head, tag and count memories, counters, result register.
// Depends on dlm_pkg and dlm_ram; steered by dlm_ctrl commands.
`timescale 1ns / 1ps

module dlm_dpath #(
	parameter int MAX_COLUMNS = 64,
	parameter int POOL_NODES  = 1024,
	parameter int TAG_BITS    = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dlm_pkg::dp_cmd_t    cmd,
	output dlm_pkg::dp_status_t stat,
	input  dlm_pkg::item_t      item,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [6:0]          cfg_data,
	output logic                result_valid,
	input  logic                result_stall,
	output dlm_pkg::result_t    result
);

	localparam int FIRST = 1 + MAX_COLUMNS;
	localparam int NODES = FIRST + POOL_NODES;
	localparam int NW    = $clog2(NODES);
	localparam int HW    = $clog2(MAX_COLUMNS + 1);
	localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int PW    = $clog2(POOL_NODES + 1);
	localparam int TW    = (TAG_BITS < 32) ? TAG_BITS : 32;
	localparam int TAW   = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
	localparam int CN    = dlm_pkg::CNT_W;

	dlm_pkg::item_t   op_q;
	dlm_pkg::result_t rd_q;
	logic [6:0]       cfg_p_q, cfg_s_q, live_p_q;
	logic [7:0]       live_t_q;
	logic [PW-1:0]    pool_q, steps_q;
	logic [10:0]      rows_q, res_q;
	logic             pend_q;
	logic [2:0]       st_q;
	logic [NW-1:0]    cur_q, nxt_q, sw_q;
	logic [HW-1:0]    h_q;

	// memory ports
	logic          up_we, dn_we, lf_we, rt_we, hd_we, tg_we, sz_we;
	logic [NW-1:0] up_wa, dn_wa, lf_wa, rt_wa, hd_wa, up_ra, dn_ra, lf_ra, rt_ra, hd_ra;
	logic [NW-1:0] up_wd, dn_wd, lf_wd, rt_wd, up_rd, dn_rd, lf_rd, rt_rd;
	logic [HW-1:0] hd_wd, hd_rd;
	logic [TAW-1:0] tg_wa, tg_ra;
	logic [TW-1:0] tg_wd, tg_rd;
	logic [CW-1:0] sz_wa, sz_ra;
	logic [CN-1:0] sz_wd, sz_rd;

	logic [NW-1:0] n_new, idx_n, ring_p;
	logic [HW-1:0] col_h;
	logic          pool_full, hd_ok, hq_ok, in_ring;
	logic [2:0]    pre_status;
	dlm_pkg::result_t res_next;

	assign n_new  = NW'(FIRST) + NW'(pool_q);
	assign idx_n  = NW'(op_q.node_index);
	assign col_h  = HW'(op_q.column) + HW'(1);
	assign ring_p = NW'(live_p_q);
	assign pool_full = 32'(pool_q) >= POOL_NODES;
	assign hd_ok  = (hd_rd != '0) && (32'(hd_rd) <= MAX_COLUMNS);
	assign hq_ok  = (h_q != '0) && (32'(h_q) <= MAX_COLUMNS);
	assign in_ring = (live_p_q != '0) && (32'(sw_q) <= 32'(live_p_q));

	always_comb begin
		pre_status = dlm_pkg::ST_OK;
		unique case (op_q.opcode)
			dlm_pkg::OP_RESET: begin
				if (32'(cfg_p_q) > MAX_COLUMNS ||
				    32'(cfg_p_q) + 32'(cfg_s_q) > MAX_COLUMNS)
					pre_status = dlm_pkg::ST_BAD_CFG;
			end
			dlm_pkg::OP_BEGIN: begin
				if (pool_full) pre_status = dlm_pkg::ST_POOL_FULL;
			end
			dlm_pkg::OP_SET: begin
				priority if (pool_full) pre_status = dlm_pkg::ST_POOL_FULL;
				else if (32'(op_q.column) >= 32'(live_t_q)) pre_status = dlm_pkg::ST_BAD_COL;
				else if (!pend_q && pool_q == '0) pre_status = dlm_pkg::ST_BAD_NODE;
			end
			dlm_pkg::OP_HIDE, dlm_pkg::OP_UNHIDE: begin
				if (32'(op_q.node_index) < FIRST ||
				    32'(op_q.node_index) >= FIRST + 32'(pool_q))
					pre_status = dlm_pkg::ST_BAD_NODE;
			end
			dlm_pkg::OP_READ: begin
				if (32'(op_q.node_index) >= NODES) pre_status = dlm_pkg::ST_BAD_NODE;
			end
			default: pre_status = dlm_pkg::ST_OK;
		endcase
	end

	always_comb begin
		stat.opcode     = op_q.opcode;
		stat.pre_err    = pre_status != dlm_pkg::ST_OK;
		stat.sweep_last = 32'(sw_q) == MAX_COLUMNS;
		stat.out_free   = !result_valid || !result_stall;
		if (cmd.step == dlm_pkg::CMD_UNH4 || cmd.step == dlm_pkg::CMD_HID3)
			stat.walk_last = (nxt_q == idx_n) || (32'(steps_q) + 1 >= POOL_NODES);
		else
			stat.walk_last = 1'b0;
	end

	// memory port steering
	always_comb begin
		up_we = 1'b0; dn_we = 1'b0; lf_we = 1'b0; rt_we = 1'b0;
		hd_we = 1'b0; tg_we = 1'b0; sz_we = 1'b0;
		up_wa = cur_q; dn_wa = cur_q; lf_wa = cur_q; rt_wa = cur_q; hd_wa = cur_q;
		up_wd = cur_q; dn_wd = cur_q; lf_wd = cur_q; rt_wd = cur_q; hd_wd = '0;
		tg_wa = TAW'(pool_q); tg_wd = TW'(op_q.row_tag);
		sz_wa = CW'(h_q - HW'(1)); sz_wd = '0;
		up_ra = cur_q; dn_ra = cur_q; lf_ra = cur_q; rt_ra = cur_q; hd_ra = cur_q;
		tg_ra = TAW'(cur_q - NW'(FIRST));
		sz_ra = CW'(hd_rd - HW'(1));
		unique case (cmd.step)
			dlm_pkg::CMD_SWEEP: begin
				up_we = 1'b1; dn_we = 1'b1; lf_we = 1'b1; rt_we = 1'b1; hd_we = 1'b1;
				up_wa = sw_q; dn_wa = sw_q; lf_wa = sw_q; rt_wa = sw_q; hd_wa = sw_q;
				up_wd = sw_q; dn_wd = sw_q; hd_wd = HW'(sw_q);
				lf_wd = sw_q; rt_wd = sw_q;
				if (in_ring) begin
					lf_wd = (sw_q == '0) ? ring_p : sw_q - NW'(1);
					rt_wd = (sw_q == ring_p) ? '0 : sw_q + NW'(1);
				end
				sz_we = sw_q != '0;
				sz_wa = CW'(sw_q - NW'(1));
			end
			dlm_pkg::CMD_BEGIN: begin
				up_we = 1'b1; dn_we = 1'b1; lf_we = 1'b1; rt_we = 1'b1; hd_we = 1'b1;
				tg_we = 1'b1;
				up_wa = n_new; dn_wa = n_new; lf_wa = n_new; rt_wa = n_new; hd_wa = n_new;
				up_wd = n_new; dn_wd = n_new; lf_wd = n_new; rt_wd = n_new;
			end
			dlm_pkg::CMD_SET1: begin
				up_ra = NW'(col_h);
				sz_ra = CW'(op_q.column);
				rt_ra = n_new - NW'(1);
				tg_ra = TAW'(pool_q - PW'(1));
			end
			dlm_pkg::CMD_SET2: begin
				dn_we = 1'b1; dn_wa = up_rd; dn_wd = n_new;
				up_we = 1'b1; up_wa = n_new; up_wd = up_rd;
				sz_we = 1'b1; sz_wa = CW'(op_q.column); sz_wd = sz_rd + CN'(1);
				hd_we = 1'b1; hd_wa = n_new; hd_wd = col_h;
				lf_we = 1'b1; rt_we = 1'b1;
				if (pend_q) begin
					lf_wa = n_new; lf_wd = n_new;
					rt_wa = n_new; rt_wd = n_new;
				end else begin
					lf_wa = rt_rd; lf_wd = n_new;
					rt_wa = n_new; rt_wd = rt_rd;
					tg_we = 1'b1; tg_wd = tg_rd;
				end
			end
			dlm_pkg::CMD_SET3: begin
				dn_we = 1'b1; dn_wa = n_new; dn_wd = NW'(col_h);
				up_we = 1'b1; up_wa = NW'(col_h); up_wd = n_new;
				if (!pend_q) begin
					lf_we = 1'b1; lf_wa = n_new; lf_wd = n_new - NW'(1);
					rt_we = 1'b1; rt_wa = n_new - NW'(1); rt_wd = n_new;
				end
			end
			dlm_pkg::CMD_HID2: begin
				dn_we = 1'b1; dn_wa = up_rd; dn_wd = dn_rd;
				up_we = 1'b1; up_wa = dn_rd; up_wd = up_rd;
			end
			dlm_pkg::CMD_HID3: begin
				sz_we = hq_ok; sz_wd = sz_rd - CN'(1);
			end
			dlm_pkg::CMD_UNH2: begin
				up_ra = NW'(hd_rd);
			end
			dlm_pkg::CMD_UNH3: begin
				dn_we = 1'b1; dn_wa = up_rd; dn_wd = cur_q;
				up_we = 1'b1; up_wa = cur_q; up_wd = up_rd;
				sz_we = hq_ok; sz_wd = sz_rd + CN'(1);
			end
			dlm_pkg::CMD_UNH4: begin
				dn_we = 1'b1; dn_wa = cur_q; dn_wd = NW'(h_q);
				up_we = 1'b1; up_wa = NW'(h_q); up_wd = cur_q;
			end
			default: begin
			end
		endcase
	end

	dlm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_up (.clk(clk), .we(up_we), .waddr(up_wa),
		.wdata(up_wd), .raddr(up_ra), .rdata(up_rd));
	dlm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_dn (.clk(clk), .we(dn_we), .waddr(dn_wa),
		.wdata(dn_wd), .raddr(dn_ra), .rdata(dn_rd));
	dlm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_lf (.clk(clk), .we(lf_we), .waddr(lf_wa),
		.wdata(lf_wd), .raddr(lf_ra), .rdata(lf_rd));
	dlm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_rt (.clk(clk), .we(rt_we), .waddr(rt_wa),
		.wdata(rt_wd), .raddr(rt_ra), .rdata(rt_rd));
	dlm_ram #(.WIDTH(HW), .DEPTH(NODES)) u_hd (.clk(clk), .we(hd_we), .waddr(hd_wa),
		.wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
	dlm_ram #(.WIDTH(TW), .DEPTH(POOL_NODES)) u_tg (.clk(clk), .we(tg_we), .waddr(tg_wa),
		.wdata(tg_wd), .raddr(tg_ra), .rdata(tg_rd));
	dlm_ram #(.WIDTH(CN), .DEPTH(MAX_COLUMNS)) u_sz (.clk(clk), .we(sz_we), .waddr(sz_wa),
		.wdata(sz_wd), .raddr(sz_ra), .rdata(sz_rd));

	always_comb begin
		res_next             = rd_q;
		res_next.status      = st_q;
		res_next.result_node = res_q;
		res_next.rows_total  = rows_q;
		res_next.nodes_total = 11'(pool_q);
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) op_q <= item;
		unique case (cmd.step)
			dlm_pkg::CMD_DECODE: begin
				st_q    <= pre_status;
				res_q   <= '0;
				rd_q    <= '0;
				cur_q   <= idx_n;
				steps_q <= '0;
			end
			dlm_pkg::CMD_BEGIN: res_q <= 11'(n_new);
			dlm_pkg::CMD_HID2: begin
				h_q   <= hd_rd;
				nxt_q <= rt_rd;
			end
			dlm_pkg::CMD_HID3: begin
				cur_q   <= nxt_q;
				steps_q <= steps_q + PW'(1);
			end
			dlm_pkg::CMD_UNH2: begin
				h_q   <= hd_rd;
				nxt_q <= lf_rd;
			end
			dlm_pkg::CMD_UNH4: begin
				cur_q   <= nxt_q;
				steps_q <= steps_q + PW'(1);
			end
			dlm_pkg::CMD_RD3: begin
				rd_q.link_up      <= 11'(up_rd);
				rd_q.link_down    <= 11'(dn_rd);
				rd_q.link_left    <= 11'(lf_rd);
				rd_q.link_right   <= 11'(rt_rd);
				rd_q.head_column  <= 7'(hd_rd);
				rd_q.tag_out      <= (32'(cur_q) >= FIRST) ? 32'(tg_rd) : '0;
				rd_q.column_count <= hd_ok ? sz_rd : '0;
			end
			dlm_pkg::CMD_DONE: begin
				if (stat.out_free) result <= res_next;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_p_q      <= '0;
			cfg_s_q      <= '0;
			live_p_q     <= '0;
			live_t_q     <= '0;
			pool_q       <= '0;
			rows_q       <= '0;
			pend_q       <= 1'b0;
			sw_q         <= '0;
			result_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					dlm_pkg::CFG_PRIMARY:   cfg_p_q <= cfg_data;
					dlm_pkg::CFG_SECONDARY: cfg_s_q <= cfg_data;
					default:                cfg_p_q <= cfg_p_q;
				endcase
			end
			if (cmd.step == dlm_pkg::CMD_SWEEP) begin
				sw_q   <= sw_q + NW'(1);
				pool_q <= '0;
				rows_q <= '0;
				pend_q <= 1'b0;
			end else begin
				sw_q <= '0;
			end
			if (cmd.step == dlm_pkg::CMD_DECODE && op_q.opcode == dlm_pkg::OP_RESET &&
			    pre_status == dlm_pkg::ST_OK) begin
				live_p_q <= cfg_p_q;
				live_t_q <= 8'(cfg_p_q) + 8'(cfg_s_q);
			end
			if (cmd.step == dlm_pkg::CMD_BEGIN) begin
				pend_q <= 1'b1;
				if (rows_q != dlm_pkg::ROWS_MAX) rows_q <= rows_q + 11'd1;
			end
			if (cmd.step == dlm_pkg::CMD_SET3) begin
				pend_q <= 1'b0;
				pool_q <= pool_q + PW'(1);
			end
			if (cmd.step == dlm_pkg::CMD_DONE && stat.out_free)
				result_valid <= 1'b1;
			else if (!result_stall)
				result_valid <= 1'b0;
		end
	end

endmodule

// ===== hw/rtl/dlm_ctrl.sv =====
// Controller state machine: sequences each operation's memory steps.
// Depends on dlm_pkg; drives dlm_dpath through dp_cmd_t.
`timescale 1ns / 1ps

module dlm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  dlm_pkg::dp_status_t stat,
	output dlm_pkg::dp_cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_SWEEP, S_DECODE, S_BEGIN,
		S_SET1, S_SET2, S_SET3,
		S_HID1, S_HID2, S_HID3,
		S_UNH1, S_UNH2, S_UNH3, S_UNH4,
		S_RD1, S_RD2, S_RD3,
		S_DONE
	} state_t;

	state_t state_q;
	logic   sweep_op_q;

	assign item_stall = state_q != S_IDLE;

	always_comb begin
		cmd.load = item_valid && state_q == S_IDLE;
		unique case (state_q)
			S_IDLE:   cmd.step = dlm_pkg::CMD_IDLE;
			S_SWEEP:  cmd.step = dlm_pkg::CMD_SWEEP;
			S_DECODE: cmd.step = dlm_pkg::CMD_DECODE;
			S_BEGIN:  cmd.step = dlm_pkg::CMD_BEGIN;
			S_SET1:   cmd.step = dlm_pkg::CMD_SET1;
			S_SET2:   cmd.step = dlm_pkg::CMD_SET2;
			S_SET3:   cmd.step = dlm_pkg::CMD_SET3;
			S_HID1:   cmd.step = dlm_pkg::CMD_HID1;
			S_HID2:   cmd.step = dlm_pkg::CMD_HID2;
			S_HID3:   cmd.step = dlm_pkg::CMD_HID3;
			S_UNH1:   cmd.step = dlm_pkg::CMD_UNH1;
			S_UNH2:   cmd.step = dlm_pkg::CMD_UNH2;
			S_UNH3:   cmd.step = dlm_pkg::CMD_UNH3;
			S_UNH4:   cmd.step = dlm_pkg::CMD_UNH4;
			S_RD1:    cmd.step = dlm_pkg::CMD_RD1;
			S_RD2:    cmd.step = dlm_pkg::CMD_RD2;
			S_RD3:    cmd.step = dlm_pkg::CMD_RD3;
			S_DONE:   cmd.step = dlm_pkg::CMD_DONE;
			default:  cmd.step = dlm_pkg::CMD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_SWEEP;
			sweep_op_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (item_valid) state_q <= S_DECODE;
				S_SWEEP: begin
					if (stat.sweep_last) state_q <= sweep_op_q ? S_DONE : S_IDLE;
				end
				S_DECODE: begin
					if (stat.pre_err) begin
						state_q <= S_DONE;
					end else begin
						unique case (stat.opcode)
							dlm_pkg::OP_RESET: begin
								state_q    <= S_SWEEP;
								sweep_op_q <= 1'b1;
							end
							dlm_pkg::OP_BEGIN:  state_q <= S_BEGIN;
							dlm_pkg::OP_SET:    state_q <= S_SET1;
							dlm_pkg::OP_HIDE:   state_q <= S_HID1;
							dlm_pkg::OP_UNHIDE: state_q <= S_UNH1;
							dlm_pkg::OP_READ:   state_q <= S_RD1;
							default:            state_q <= S_DONE;
						endcase
					end
				end
				S_BEGIN: state_q <= S_DONE;
				S_SET1:  state_q <= S_SET2;
				S_SET2:  state_q <= S_SET3;
				S_SET3:  state_q <= S_DONE;
				S_HID1:  state_q <= S_HID2;
				S_HID2:  state_q <= S_HID3;
				S_HID3:  state_q <= stat.walk_last ? S_DONE : S_HID1;
				S_UNH1:  state_q <= S_UNH2;
				S_UNH2:  state_q <= S_UNH3;
				S_UNH3:  state_q <= S_UNH4;
				S_UNH4:  state_q <= stat.walk_last ? S_DONE : S_UNH1;
				S_RD1:   state_q <= S_RD2;
				S_RD2:   state_q <= S_RD3;
				S_RD3:   state_q <= S_DONE;
				S_DONE: begin
					sweep_op_q <= 1'b0;
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/dancing_links_matrix_core.sv =====
// Dancing-links matrix core: one item at a time, one result transfer per item.
// Each item is decoded, then runs its operation's memory steps; reset runs the header
// sweep, and bad or unknown ops go straight to the result step. Hide and unhide walk
// the row ring node by node until back at the given node or after POOL_NODES nodes.
// After arst_n a header pass over nodes 0 to MAX_COLUMNS runs before the first item is taken.
// Pool nodes and tags hold no reset value; pool and row counters and config registers clear.
`timescale 1ns / 1ps

module dancing_links_matrix_core #(
	parameter int MAX_COLUMNS = 64,
	parameter int POOL_NODES  = 1024,
	parameter int TAG_BITS    = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	// item channel
	input  logic             item_valid,
	output logic             item_stall,
	input  dlm_pkg::item_t   item,
	// result channel
	output logic             result_valid,
	input  logic             result_stall,
	output dlm_pkg::result_t result,
	// configuration writes, index 0 primary, 1 secondary
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [6:0]       cfg_data
);

	// Controller sequences memory steps; datapath owns all storage.
	dlm_pkg::dp_cmd_t    cmd;
	dlm_pkg::dp_status_t stat;

	dlm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	// The result register lets the next item start while a transfer is pending;
	// only the final step waits for it to drain.
	dlm_dpath #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.POOL_NODES  (POOL_NODES),
		.TAG_BITS    (TAG_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
